### sv/nearest_target_select_and_aim_assert.svh
// Assertion macros used by the bound checker file.
`ifndef NEAREST_TARGET_SELECT_AND_AIM_ASSERT_SVH
`define NEAREST_TARGET_SELECT_AND_AIM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTSA_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed in nearest target selector");

// The consequent must hold in the cycle after the antecedent.
`define NTSA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed in nearest target selector");

`endif

### sv/ntsa_pkg.sv
`default_nettype none

package ntsa_pkg;

  // Fixed field widths.
  localparam int COORD_BITS = 14;
  localparam int GAIN_W     = 16;
  localparam int BIAS_W     = 20;
  localparam int ANGLE_W    = 16;
  localparam int POS_W      = 4;

  // Fixed-point scaling: 1/32 pixel times Q8.8 gain gives 2^13 per mrad.
  localparam int FRAC_SHIFT = 13;
  localparam int BIAS_SHIFT = 9;

  localparam int MAX_BOXES_DEF = 16;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register reset values.
  localparam logic                  ENEMY_CLASS_RST = 1'b0;
  localparam logic [COORD_BITS-1:0] CENTER_X_RST    = COORD_BITS'(1664);
  localparam logic [COORD_BITS-1:0] CENTER_Y_RST    = COORD_BITS'(1664);
  localparam logic [GAIN_W-1:0]     PAN_GAIN_RST    = GAIN_W'(2560);
  localparam logic [GAIN_W-1:0]     TILT_GAIN_RST   = GAIN_W'(256);
  localparam logic [BIAS_W-1:0]     TILT_BIAS_RST   = BIAS_W'(25133);

  typedef enum logic [2:0] {
    REG_ENEMY_CLASS = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_PAN_GAIN    = 3'd3,
    REG_TILT_GAIN   = 3'd4,
    REG_TILT_BIAS   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic                  enemy_class;
    logic [COORD_BITS-1:0] center_x_offset;
    logic [COORD_BITS-1:0] center_y_offset;
    logic [GAIN_W-1:0]     pan_gain;
    logic [GAIN_W-1:0]     tilt_gain;
    logic [BIAS_W-1:0]     tilt_bias;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_w;
    logic [COORD_BITS-1:0] box_h;
    logic                  box_class;
    logic                  last_box;
  } box_in_t;

  typedef struct packed {
    logic        [ANGLE_W-1:0] tilt_mrad;
    logic signed [ANGLE_W-1:0] pan_mrad;
    logic        [POS_W-1:0]   chosen_index;
  } aim_out_t;

  // Chosen box handed from the selector to the aim pipeline.
  typedef struct packed {
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_w;
    logic [COORD_BITS-1:0] box_h;
    logic [POS_W-1:0]      pos;
  } aim_req_t;

endpackage

`default_nettype wire

### sv/ntsa_regs.sv
`default_nettype none

module ntsa_regs import ntsa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes; unknown addresses are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enemy_class     <= ENEMY_CLASS_RST;
      cfg_q.center_x_offset <= CENTER_X_RST;
      cfg_q.center_y_offset <= CENTER_Y_RST;
      cfg_q.pan_gain        <= PAN_GAIN_RST;
      cfg_q.tilt_gain       <= TILT_GAIN_RST;
      cfg_q.tilt_bias       <= TILT_BIAS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ENEMY_CLASS: cfg_q.enemy_class     <= pwdata[0];
        REG_CENTER_X:    cfg_q.center_x_offset <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y:    cfg_q.center_y_offset <= pwdata[COORD_BITS-1:0];
        REG_PAN_GAIN:    cfg_q.pan_gain        <= pwdata[GAIN_W-1:0];
        REG_TILT_GAIN:   cfg_q.tilt_gain       <= pwdata[GAIN_W-1:0];
        REG_TILT_BIAS:   cfg_q.tilt_bias       <= pwdata[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (idx)
      REG_ENEMY_CLASS: prdata = DATA_W'(cfg_q.enemy_class);
      REG_CENTER_X:    prdata = DATA_W'(cfg_q.center_x_offset);
      REG_CENTER_Y:    prdata = DATA_W'(cfg_q.center_y_offset);
      REG_PAN_GAIN:    prdata = DATA_W'(cfg_q.pan_gain);
      REG_TILT_GAIN:   prdata = DATA_W'(cfg_q.tilt_gain);
      REG_TILT_BIAS:   prdata = DATA_W'(cfg_q.tilt_bias);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/ntsa_aim.sv
`default_nettype none

module ntsa_aim import ntsa_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  input  aim_req_t      req_i,
  output logic          req_ready_o,
  input  cfg_t          cfg_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output aim_out_t      out_o
);

  // Centers in 1/32 pixel need three bits above the coordinate width.
  localparam int CW = COORD_BITS + 3;
  localparam int MW = CW + GAIN_W + 1;
  localparam int PW = MW + 1;
  localparam int QW = PW - FRAC_SHIFT;
  localparam logic signed [QW-1:0] TILT_MAX = QW'((1 << ANGLE_W) - 1);
  localparam logic signed [QW-1:0] PAN_MAX  = QW'((1 << (ANGLE_W - 1)) - 1);
  localparam logic signed [QW-1:0] PAN_MIN  = -QW'(1 << (ANGLE_W - 1));

  logic     req_valid_q, prod_valid_q, out_valid_q;
  logic     req_adv, prod_adv, out_adv;
  aim_req_t req_q;

  logic signed [PW-1:0] tilt_sum_q, pan_prod_q;
  logic [POS_W-1:0]     pos_q;
  aim_out_t             out_q;

  logic signed [CW-1:0]     cy_s, cx_s;
  logic signed [GAIN_W:0]   tilt_g, pan_g;
  logic signed [MW-1:0]     tilt_prod, pan_prod;
  logic signed [PW-1:0]     tilt_ext, pan_ext, bias_s, tilt_sum_d;
  logic signed [PW-1:0]     tilt_sh, pan_sh;
  logic signed [QW-1:0]     theta_s, phi_s;
  aim_out_t                 out_d;

  // Each stage moves when the one after it is empty or moving.
  assign out_adv     = !out_valid_q || out_ready_i;
  assign prod_adv    = !prod_valid_q || out_adv;
  assign req_adv     = !req_valid_q || prod_adv;
  assign req_ready_o = req_adv;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q  <= 1'b0;
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (req_adv) req_valid_q <= req_valid_i;
      if (prod_adv) prod_valid_q <= req_valid_q;
      if (out_adv) out_valid_q <= prod_valid_q;
    end
  end

  // Offsets of the box center from the aim origin, in 1/32 pixel.
  assign cy_s = $signed({2'b00, req_q.box_y, 1'b0}) + $signed({3'b000, req_q.box_h})
              - $signed({2'b00, cfg_i.center_y_offset, 1'b0});
  assign cx_s = $signed({2'b00, req_q.box_x, 1'b0}) + $signed({3'b000, req_q.box_w})
              - $signed({2'b00, cfg_i.center_x_offset, 1'b0});

  // Scale by the gains and add the tilt bias at the same scale.
  assign tilt_g     = $signed({1'b0, cfg_i.tilt_gain});
  assign pan_g      = $signed({1'b0, cfg_i.pan_gain});
  assign tilt_prod  = MW'(cy_s) * MW'(tilt_g);
  assign pan_prod   = MW'(cx_s) * MW'(pan_g);
  assign tilt_ext   = PW'(tilt_prod);
  assign pan_ext    = PW'(pan_prod);
  assign bias_s     = $signed(PW'({cfg_i.tilt_bias, {BIAS_SHIFT{1'b0}}}));
  assign tilt_sum_d = tilt_ext + bias_s;

  always_ff @(posedge clk_i) begin
    if (req_adv && req_valid_i) req_q <= req_i;
    if (prod_adv && req_valid_q) begin
      tilt_sum_q <= tilt_sum_d;
      pan_prod_q <= pan_ext;
      pos_q      <= req_q.pos;
    end
    if (out_adv && prod_valid_q) out_q <= out_d;
  end

  // Floor to milliradians and clamp to the output ranges.
  assign tilt_sh = tilt_sum_q >>> FRAC_SHIFT;
  assign pan_sh  = pan_prod_q >>> FRAC_SHIFT;
  assign theta_s = $signed(tilt_sh[QW-1:0]);
  assign phi_s   = $signed(pan_sh[QW-1:0]);

  always_comb begin
    if (theta_s < $signed(QW'(0))) begin
      out_d.tilt_mrad = '0;
    end else if (theta_s > TILT_MAX) begin
      out_d.tilt_mrad = '1;
    end else begin
      out_d.tilt_mrad = theta_s[ANGLE_W-1:0];
    end
    if (phi_s < PAN_MIN) begin
      out_d.pan_mrad = PAN_MIN[ANGLE_W-1:0];
    end else if (phi_s > PAN_MAX) begin
      out_d.pan_mrad = PAN_MAX[ANGLE_W-1:0];
    end else begin
      out_d.pan_mrad = phi_s[ANGLE_W-1:0];
    end
    out_d.chosen_index = pos_q;
  end

endmodule

`default_nettype wire

### sv/nearest_target_select_and_aim.sv
// Nearest target selector with aim angle output.
// Input channel: one detected box per item (corner, size, class, last flag).
// Boxes are taken one per cycle while in_ready_o is high; each is compared
// against the running best box of the frame in the cycle it is accepted.
// Output channel: at most one item per frame, given after the last box if a
// box of the enemy class was seen; it carries tilt and pan in mrad and the
// position of the chosen box. Frames without a match give nothing.
// After the edge that accepts the last box, the result passes through the
// request, product and result registers of the aim pipeline before it is valid.
// Throughput: one box per cycle, and one result per cycle for frames of
// a single box, while the receiver does not stall.
// When the receiver stalls, the result holds and boxes are still taken
// until the three aim stages are full; then in_ready_o drops.
// Reset clears the reference corner to zero, empties the frame and the aim
// pipeline and loads the register defaults.
// Registers sit on an APB port at byte address 4 times their index.
`default_nettype none

module nearest_target_select_and_aim import ntsa_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  box_in_t                in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output aim_out_t               out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int CNT_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = 2 * COORD_BITS + 1;

  cfg_t     cfg;
  aim_req_t req;
  logic     req_valid, req_ready;

  logic [COORD_BITS-1:0] ref_x_q, ref_y_q;
  logic [DIST_W-1:0]     near_sq_q;
  logic                  best_found_q;
  logic [COORD_BITS-1:0] best_x_q, best_y_q, best_w_q, best_h_q;
  logic [CNT_W-1:0]      best_pos_q, cnt_q;

  logic                    accept, sel_cur, found_any;
  logic [COORD_BITS-1:0]   dx, dy;
  logic [2*COORD_BITS-1:0] dx_sq, dy_sq;
  logic [DIST_W-1:0]       sq_dist;
  logic [CNT_W-1:0]        chosen_pos;
  logic [CNT_W+POS_W-1:0]  pos_ext;

  ntsa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = req_ready;
  assign accept     = in_valid_i && in_ready_o;

  // Squared distance from the box corner to the reference corner.
  assign dx      = (in_data_i.box_x > ref_x_q) ? in_data_i.box_x - ref_x_q
                                               : ref_x_q - in_data_i.box_x;
  assign dy      = (in_data_i.box_y > ref_y_q) ? in_data_i.box_y - ref_y_q
                                               : ref_y_q - in_data_i.box_y;
  assign dx_sq   = SQ_W'(dx) * SQ_W'(dx);
  assign dy_sq   = SQ_W'(dy) * SQ_W'(dy);
  assign sq_dist = {1'b0, dx_sq} + {1'b0, dy_sq};

  // A strictly nearer box of the enemy class replaces the best one.
  assign sel_cur   = (in_data_i.box_class == cfg.enemy_class)
                   && (!best_found_q || sq_dist < near_sq_q);
  assign found_any = best_found_q || sel_cur;

  // Chosen box of the frame, including the box now at the input.
  assign chosen_pos = sel_cur ? cnt_q : best_pos_q;
  assign pos_ext    = {{POS_W{1'b0}}, chosen_pos};
  assign req.box_x  = sel_cur ? in_data_i.box_x : best_x_q;
  assign req.box_y  = sel_cur ? in_data_i.box_y : best_y_q;
  assign req.box_w  = sel_cur ? in_data_i.box_w : best_w_q;
  assign req.box_h  = sel_cur ? in_data_i.box_h : best_h_q;
  assign req.pos    = pos_ext[POS_W-1:0];
  assign req_valid  = in_valid_i && in_data_i.last_box && found_any;

  // Frame state and reference corner.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q      <= '0;
      ref_y_q      <= '0;
      near_sq_q    <= '1;
      best_found_q <= 1'b0;
      cnt_q        <= '0;
    end else if (accept) begin
      if (in_data_i.last_box) begin
        near_sq_q    <= '1;
        best_found_q <= 1'b0;
        cnt_q        <= '0;
        if (found_any) begin
          ref_x_q <= req.box_x;
          ref_y_q <= req.box_y;
        end
      end else begin
        if (sel_cur) begin
          near_sq_q    <= sq_dist;
          best_found_q <= 1'b1;
        end
        cnt_q <= (cnt_q == CNT_W'(MAX_BOXES - 1)) ? '0 : cnt_q + CNT_W'(1);
      end
    end
  end

  // Best box payload, read only while the frame has a match.
  always_ff @(posedge clk_i) begin
    if (accept && sel_cur) begin
      best_x_q   <= in_data_i.box_x;
      best_y_q   <= in_data_i.box_y;
      best_w_q   <= in_data_i.box_w;
      best_h_q   <= in_data_i.box_h;
      best_pos_q <= cnt_q;
    end
  end

  ntsa_aim u_aim (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_ready_o (req_ready),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

endmodule

`default_nettype wire

### sv/ntsa_checker.sv
`default_nettype none
`include "nearest_target_select_and_aim_assert.svh"

module ntsa_checker import ntsa_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input box_in_t                in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input aim_out_t               out_data_o,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [ADDR_W-1:0] paddr,
  input wire logic [DATA_W-1:0] pwdata,
  input wire logic [DATA_W-1:0] prdata,
  input wire logic              pready
);

  logic pan_gain_wr, same_addr_rd;

  assign pan_gain_wr  = psel && penable && pwrite && pready
                      && (paddr[ADDR_W-1:2] == REG_PAN_GAIN);
  assign same_addr_rd = psel && !pwrite && (paddr[ADDR_W-1:2] == REG_PAN_GAIN);

  // A held result stays valid and unchanged.
  `NTSA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `NTSA_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o))

  // Input backpressure only arises from a result waiting at the output.
  `NTSA_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o)

  // A written pan gain reads back on the next cycle.
  `NTSA_ASSERT_NEXT(a_gain_readback, pan_gain_wr,
                    !same_addr_rd || prdata[GAIN_W-1:0] == $past(pwdata[GAIN_W-1:0]))

endmodule

bind nearest_target_select_and_aim ntsa_checker u_ntsa_checker (.*);

`default_nettype wire

### dv/nearest_target_aim_checker.sv
module nearest_target_aim_checker import ntsa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  box_in_t                in_data_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  aim_out_t               out_data_i,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output int                     mismatch_cnt_o,
  output int                     pending_o,
  output int                     results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIST_W = 2 * COORD_BITS + 1;

  // Shadow copy of the registers, as seen on completed APB writes.
  cfg_t cfg;

  // Tracking state: reference corner and the running best box of the frame.
  logic [COORD_BITS-1:0] ref_x;
  logic [COORD_BITS-1:0] ref_y;
  logic [DIST_W-1:0]     near_sq;
  logic                  best_found;
  box_in_t               best_box;
  logic [POS_W-1:0]      best_pos;
  logic [POS_W-1:0]      box_count;

  // Aim items still owed by the block, oldest first.
  aim_out_t expected_aims[$];

  // Aim angles for a chosen box under the current register settings.
  function automatic aim_out_t aim_for(box_in_t b, logic [POS_W-1:0] pos);
    aim_out_t res;
    longint cy;
    longint cx;
    longint tilt;
    longint pan;
    // Centers in 1/32 pixel; 1/32 px times Q8.8 gain is 2^13 per mrad.
    cy = 2 * longint'(b.box_y) + longint'(b.box_h) - 2 * longint'(cfg.center_y_offset);
    cx = 2 * longint'(b.box_x) + longint'(b.box_w) - 2 * longint'(cfg.center_x_offset);
    tilt = (cy * longint'(cfg.tilt_gain) + longint'(cfg.tilt_bias) * 512) >>> 13;
    pan = (cx * longint'(cfg.pan_gain)) >>> 13;
    if (tilt < 0) tilt = 0;
    if (tilt > 65535) tilt = 65535;
    if (pan < -32768) pan = -32768;
    if (pan > 32767) pan = 32767;
    res.tilt_mrad = tilt[ANGLE_W-1:0];
    res.pan_mrad = pan[ANGLE_W-1:0];
    res.chosen_index = pos;
    return res;
  endfunction

  // Register write decoded by word address.
  task automatic write_cfg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    case (reg_idx_e'(addr[ADDR_W-1:2]))
      REG_ENEMY_CLASS: cfg.enemy_class = data[0];
      REG_CENTER_X:    cfg.center_x_offset = data[COORD_BITS-1:0];
      REG_CENTER_Y:    cfg.center_y_offset = data[COORD_BITS-1:0];
      REG_PAN_GAIN:    cfg.pan_gain = data[GAIN_W-1:0];
      REG_TILT_GAIN:   cfg.tilt_gain = data[GAIN_W-1:0];
      REG_TILT_BIAS:   cfg.tilt_bias = data[BIAS_W-1:0];
      default: ;
    endcase
  endtask

  // One accepted box: update the frame's best and close the frame on the last box.
  task automatic take_box(box_in_t b);
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [DIST_W-1:0]     sq_dist;
    dx = (b.box_x > ref_x) ? b.box_x - ref_x : ref_x - b.box_x;
    dy = (b.box_y > ref_y) ? b.box_y - ref_y : ref_y - b.box_y;
    sq_dist = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
    // Strict compare keeps the earlier box on a tie.
    if (b.box_class == cfg.enemy_class && (!best_found || sq_dist < near_sq)) begin
      best_found = 1'b1;
      near_sq = sq_dist;
      best_box = b;
      best_pos = box_count;
    end
    box_count = box_count + POS_W'(1);
    if (b.last_box) begin
      if (best_found) begin
        expected_aims.push_back(aim_for(best_box, best_pos));
        ref_x = best_box.box_x;
        ref_y = best_box.box_y;
      end
      best_found = 1'b0;
      near_sq = '1;
      box_count = '0;
    end
  endtask

  // One accepted aim item against the oldest expectation.
  task automatic check_aim(aim_out_t got);
    aim_out_t want;
    if (expected_aims.size() == 0) begin
      $error("aim item with none expected: tilt_mrad %0d pan_mrad %0d chosen_index %0d",
             got.tilt_mrad, got.pan_mrad, got.chosen_index);
      mismatch_cnt_o++;
    end else begin
      want = expected_aims.pop_front();
      results_o++;
      if (got.tilt_mrad !== want.tilt_mrad) begin
        $error("tilt_mrad: expected %0d, actual %0d", want.tilt_mrad, got.tilt_mrad);
        mismatch_cnt_o++;
      end
      if (got.pan_mrad !== want.pan_mrad) begin
        $error("pan_mrad: expected %0d, actual %0d", want.pan_mrad, got.pan_mrad);
        mismatch_cnt_o++;
      end
      if (got.chosen_index !== want.chosen_index) begin
        $error("chosen_index: expected %0d, actual %0d", want.chosen_index,
               got.chosen_index);
        mismatch_cnt_o++;
      end
    end
  endtask

  // Watch all three ports on every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.enemy_class = ENEMY_CLASS_RST;
      cfg.center_x_offset = CENTER_X_RST;
      cfg.center_y_offset = CENTER_Y_RST;
      cfg.pan_gain = PAN_GAIN_RST;
      cfg.tilt_gain = TILT_GAIN_RST;
      cfg.tilt_bias = TILT_BIAS_RST;
      ref_x = '0;
      ref_y = '0;
      near_sq = '1;
      best_found = 1'b0;
      best_box = '0;
      best_pos = '0;
      box_count = '0;
      expected_aims.delete();
      mismatch_cnt_o = 0;
      pending_o = 0;
      results_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) write_cfg(paddr, pwdata);
      if (out_valid_i && out_ready_i) check_aim(out_data_i);
      if (in_valid_i && in_ready_i) take_box(in_data_i);
      pending_o = expected_aims.size();
    end
  end

endmodule

### dv/nearest_target_select_and_aim_tb.sv
module nearest_target_select_and_aim_tb import ntsa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASES         = 8;
  localparam int PHASE_BOXES    = 200;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  box_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  aim_out_t              out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  int   mismatches;
  int   pending;
  int   results;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   hold_reqs = 0;
  int   hold_done = 0;
  int   idle_cycles = 0;
  int   boxes_sent = 0;
  int   frames_sent = 0;
  int   settings_used = 0;
  cfg_t cur_cfg;

  always #1 clk_i = ~clk_i;

  nearest_target_select_and_aim i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  nearest_target_aim_checker i_aim_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .results_o      (results)
  );

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_reqs) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done++;
      end
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Stop the run if nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic box_in_t mk_box(int x, int y, int w, int h, logic cls, logic last);
    box_in_t b;
    b.box_x = COORD_BITS'(x);
    b.box_y = COORD_BITS'(y);
    b.box_w = COORD_BITS'(w);
    b.box_h = COORD_BITS'(h);
    b.box_class = cls;
    b.last_box = last;
    return b;
  endfunction

  // Coordinates lean toward the ends of the range now and then.
  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return COORD_BITS'($urandom_range(16383));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    if ($urandom_range(3) == 0) return GAIN_W'($urandom_range(65535));
    return GAIN_W'($urandom_range(3072));
  endfunction

  // Offer one box, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_box(box_in_t b);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk_i); while (!in_ready);
    boxes_sent++;
    if (b.last_box) frames_sent++;
  endtask

  // Stop offering and wait until every owed aim item has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(cfg_t c);
    write_reg(REG_ENEMY_CLASS, DATA_W'(c.enemy_class));
    write_reg(REG_CENTER_X, DATA_W'(c.center_x_offset));
    write_reg(REG_CENTER_Y, DATA_W'(c.center_y_offset));
    write_reg(REG_PAN_GAIN, DATA_W'(c.pan_gain));
    write_reg(REG_TILT_GAIN, DATA_W'(c.tilt_gain));
    write_reg(REG_TILT_BIAS, DATA_W'(c.tilt_bias));
    cur_cfg = c;
    settings_used++;
  endtask

  // A well-formed frame of random boxes; repeated corners give distance ties.
  task automatic send_frame();
    box_in_t b;
    int      len;
    len = ($urandom_range(15) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if (i == 0 || $urandom_range(7) != 0) begin
        b.box_x = rand_coord();
        b.box_y = rand_coord();
      end
      b.box_w = rand_coord();
      b.box_h = rand_coord();
      b.box_class = ($urandom_range(99) < 65) ? cur_cfg.enemy_class : ~cur_cfg.enemy_class;
      b.last_box = (i == len - 1);
      send_box(b);
    end
  endtask

  task automatic send_frames(int n_boxes);
    int target;
    target = boxes_sent + n_boxes;
    while (boxes_sent < target) send_frame();
  endtask

  initial begin
    cfg_t c;
    cur_cfg = '{ENEMY_CLASS_RST, CENTER_X_RST, CENTER_Y_RST, PAN_GAIN_RST,
                TILT_GAIN_RST, TILT_BIAS_RST};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset settings.
    send_box(mk_box(0, 0, 0, 0, 0, 1));
    // No box of the enemy class: no item, reference kept.
    send_box(mk_box(16383, 16383, 16383, 16383, 1, 1));
    // Equal distances from the reference: the first box wins.
    send_box(mk_box(100, 0, 16383, 0, 0, 0));
    send_box(mk_box(0, 100, 0, 16383, 0, 1));
    // A nearer box later in the frame wins; a box of the other class is ignored.
    send_box(mk_box(5000, 5000, 7, 9, 0, 0));
    send_box(mk_box(10, 10, 300, 200, 0, 0));
    send_box(mk_box(0, 0, 1, 1, 1, 1));
    // Frame longer than the box counter: the winner sits where the count wraps.
    for (int i = 0; i < 16; i++) send_box(mk_box(16000 - i, 16000, i, i, 0, 0));
    send_box(mk_box(10, 10, 16383, 16383, 0, 1));
    wait_drained();

    // Extreme gains and origin: both angles clamp at either end.
    apply_cfg('{1'b1, '1, '1, '1, '1, '0});
    send_box(mk_box(0, 0, 0, 0, 1, 1));
    send_box(mk_box(16383, 16383, 16383, 16383, 1, 1));
    wait_drained();

    // Random phases, each with its own settings and idling pattern.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: c = '{1'b1, '1, '1, '1, '1, '1};
        1: c = '{1'b0, '0, '0, '0, '0, '0};
        2: c = '{ENEMY_CLASS_RST, CENTER_X_RST, CENTER_Y_RST, PAN_GAIN_RST,
                 TILT_GAIN_RST, TILT_BIAS_RST};
        default: c = '{1'($urandom_range(1)), COORD_BITS'($urandom_range(16383)),
                       COORD_BITS'($urandom_range(16383)), rand_gain(), rand_gain(),
                       BIAS_W'($urandom_range(1048575))};
      endcase
      apply_cfg(c);
      case (phase % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 59;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 59;
        end
        default: begin
          tx_idle_pct = 37;
          rx_stall_pct = 37;
        end
      endcase
      // Long hold-off on the result side while boxes keep coming.
      if (phase % 4 == 0) hold_reqs++;
      send_frames(PHASE_BOXES / 2);
      // Mid-phase pause until the block has handed out everything.
      if (phase == 3) wait_drained();
      send_frames(PHASE_BOXES / 2);
      wait_drained();
    end

    $display("summary: %0d boxes in %0d frames, %0d aim items checked", boxes_sent,
             frames_sent, results);
    $display("summary: %0d register settings, stalls and gaps on both channels",
             settings_used + 1);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
